FILE: src/spq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and codes for the sorted priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int PRIO_BITS = 4;
  localparam int IO_TAG_BITS = 16;
  localparam int OCC_BITS = 4;

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_REMOVE = 1'b1;

  typedef struct packed {
    logic                   kind;
    logic                   has_priority;
    logic [PRIO_BITS-1:0]   priority_req;
    logic [IO_TAG_BITS-1:0] tag;
  } in_item_t;

  typedef struct packed {
    logic                   accepted;
    logic                   dropped;
    logic [PRIO_BITS-1:0]   removed_priority;
    logic [IO_TAG_BITS-1:0] removed_tag;
    logic                   top_valid;
    logic [PRIO_BITS-1:0]   top_priority;
    logic [IO_TAG_BITS-1:0] top_tag;
    logic [OCC_BITS-1:0]    occupancy;
  } out_item_t;

  // operation broadcast to every cell of the chain
  typedef struct packed {
    logic do_insert;
    logic do_remove;
  } cell_ctrl_t;

endpackage

FILE: src/spq_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted chain: compares the new entry with its own and
// takes the new entry, its upper neighbor, its lower neighbor or holds.
// ----------------------------------------------------------------------------
module spq_cell #(
  parameter int TAG_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  spq_pkg::cell_ctrl_t              ctrl,
  input  logic [spq_pkg::PRIO_BITS-1:0]    new_prio,
  input  logic [TAG_BITS-1:0]              new_tag,
  // upper neighbor (toward the top)
  input  logic                             up_gt,
  input  logic                             up_valid,
  input  logic [spq_pkg::PRIO_BITS-1:0]    up_prio,
  input  logic [TAG_BITS-1:0]              up_tag,
  // lower neighbor (toward the tail)
  input  logic                             dn_valid,
  input  logic [spq_pkg::PRIO_BITS-1:0]    dn_prio,
  input  logic [TAG_BITS-1:0]              dn_tag,
  output logic                             gt,
  output logic                             valid,
  output logic [spq_pkg::PRIO_BITS-1:0]    prio,
  output logic [TAG_BITS-1:0]              tag
);

  logic                          valid_r, valid_nxt;
  logic [spq_pkg::PRIO_BITS-1:0] prio_r, prio_nxt;
  logic [TAG_BITS-1:0]           tag_r, tag_nxt;

  // new entry goes ahead of an empty slot or a strictly smaller entry
  assign gt = !valid_r || ({new_prio, new_tag} > {prio_r, tag_r});

  always_comb begin
    valid_nxt = valid_r;
    prio_nxt  = prio_r;
    tag_nxt   = tag_r;
    if (ctrl.do_remove) begin
      valid_nxt = dn_valid;
      prio_nxt  = dn_prio;
      tag_nxt   = dn_tag;
    end else if (ctrl.do_insert && gt) begin
      if (up_gt) begin
        valid_nxt = up_valid;
        prio_nxt  = up_prio;
        tag_nxt   = up_tag;
      end else begin
        valid_nxt = 1'b1;
        prio_nxt  = new_prio;
        tag_nxt   = new_tag;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prio_r <= prio_nxt;
    tag_r  <= tag_nxt;
  end

  assign valid = valid_r;
  assign prio  = prio_r;
  assign tag   = tag_r;

endmodule

FILE: src/sorted_priority_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Fixed-depth priority queue held sorted in a chain of compare-and-shift cells.
// ----------------------------------------------------------------------------
// One item (insert or remove) is taken per clock: every cell compares the new
// entry with its own in parallel and shifts by one slot, and the item's result
// appears in the output register on the next cycle.
// Input stalls only while a result is waiting and the output is stalled.
// Entries order by priority, then tag; equal entries leave in arrival order.
// Inserting into a full queue drops the smallest entry and flags it.
module sorted_priority_queue #(
  parameter int DEPTH    = 8,
  parameter int TAG_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  spq_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output spq_pkg::out_item_t out_item
);

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int PW    = spq_pkg::PRIO_BITS;

  logic                in_accept;
  spq_pkg::cell_ctrl_t ctrl;
  logic [PW-1:0]       new_prio;
  logic [TAG_BITS-1:0] new_tag;

  logic                c_gt    [DEPTH];
  logic                c_valid [DEPTH];
  logic [PW-1:0]       c_prio  [DEPTH];
  logic [TAG_BITS-1:0] c_tag   [DEPTH];

  logic [CNT_W-1:0]    count_r, count_nxt;
  logic                out_valid_r, out_valid_nxt;
  spq_pkg::out_item_t  out_item_r, out_item_nxt;

  logic                top_valid_nxt;
  logic [PW-1:0]       top_prio_nxt;
  logic [TAG_BITS-1:0] top_tag_nxt;
  logic                full;

  assign in_stall  = out_valid_r && out_stall;
  assign in_accept = in_valid && !in_stall;
  assign new_prio  = in_item.priority_req;
  assign new_tag   = TAG_BITS'(in_item.tag);
  assign full      = c_valid[DEPTH-1];

  assign ctrl.do_insert = in_accept && (in_item.kind == spq_pkg::KIND_INSERT)
                          && in_item.has_priority;
  assign ctrl.do_remove = in_accept && (in_item.kind == spq_pkg::KIND_REMOVE)
                          && c_valid[0];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                up_gt_w, up_valid_w, dn_valid_w;
    logic [PW-1:0]       up_prio_w, dn_prio_w;
    logic [TAG_BITS-1:0] up_tag_w, dn_tag_w;

    if (i == 0) begin : g_head
      assign up_gt_w    = 1'b0;
      assign up_valid_w = 1'b0;
      assign up_prio_w  = '0;
      assign up_tag_w   = '0;
    end else begin : g_mid
      assign up_gt_w    = c_gt[i-1];
      assign up_valid_w = c_valid[i-1];
      assign up_prio_w  = c_prio[i-1];
      assign up_tag_w   = c_tag[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign dn_valid_w = 1'b0;
      assign dn_prio_w  = '0;
      assign dn_tag_w   = '0;
    end else begin : g_body
      assign dn_valid_w = c_valid[i+1];
      assign dn_prio_w  = c_prio[i+1];
      assign dn_tag_w   = c_tag[i+1];
    end

    spq_cell #(
      .TAG_BITS (TAG_BITS)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctrl     (ctrl),
      .new_prio (new_prio),
      .new_tag  (new_tag),
      .up_gt    (up_gt_w),
      .up_valid (up_valid_w),
      .up_prio  (up_prio_w),
      .up_tag   (up_tag_w),
      .dn_valid (dn_valid_w),
      .dn_prio  (dn_prio_w),
      .dn_tag   (dn_tag_w),
      .gt       (c_gt[i]),
      .valid    (c_valid[i]),
      .prio     (c_prio[i]),
      .tag      (c_tag[i])
    );
  end

  // head of the chain after this item
  always_comb begin
    top_valid_nxt = c_valid[0];
    top_prio_nxt  = c_prio[0];
    top_tag_nxt   = c_tag[0];
    if (ctrl.do_remove) begin
      top_valid_nxt = c_valid[1];
      top_prio_nxt  = c_prio[1];
      top_tag_nxt   = c_tag[1];
    end else if (ctrl.do_insert && c_gt[0]) begin
      top_valid_nxt = 1'b1;
      top_prio_nxt  = new_prio;
      top_tag_nxt   = new_tag;
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (ctrl.do_insert && !full) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (ctrl.do_remove) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_comb begin
    out_item_nxt                  = out_item_r;
    out_valid_nxt                 = out_valid_r && out_stall;
    if (in_accept) begin
      out_valid_nxt                 = 1'b1;
      out_item_nxt.accepted         = ctrl.do_insert || ctrl.do_remove;
      out_item_nxt.dropped          = ctrl.do_insert && full;
      out_item_nxt.removed_priority = ctrl.do_remove ? c_prio[0] : '0;
      out_item_nxt.removed_tag      = ctrl.do_remove ?
                                      spq_pkg::IO_TAG_BITS'(c_tag[0]) : '0;
      out_item_nxt.top_valid        = top_valid_nxt;
      out_item_nxt.top_priority     = top_valid_nxt ? top_prio_nxt : '0;
      out_item_nxt.top_tag          = top_valid_nxt ?
                                      spq_pkg::IO_TAG_BITS'(top_tag_nxt) : '0;
      out_item_nxt.occupancy        = spq_pkg::OCC_BITS'(count_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

FILE: tb/tb_sorted_priority_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sorted_priority_queue
// Self-checking bench for the sorted priority queue: a directed table of
// inserts and removes (empty and full queue, rejected inserts, equal keys)
// followed by random traffic with idle and stall bursts, checked result by
// result against a shadow copy of the queue.
// ----------------------------------------------------------------------------
module tb_sorted_priority_queue;

  localparam int CLK_PERIOD  = 20;
  localparam int DEPTH       = 8;
  localparam int TAG_BITS    = 16;
  localparam int RAND_ITEMS  = 1125;
  localparam int QUIET_ITEMS = 150;
  localparam int HOLD_CYCLES = 40;

  typedef struct {
    spq_pkg::in_item_t  item;
    bit                 typed;
    spq_pkg::out_item_t result;
  } dir_row_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  spq_pkg::in_item_t  in_item;
  logic               out_valid;
  logic               out_stall;
  spq_pkg::out_item_t out_item;

  // shadow of the queue contents, slot 0 is the top
  logic                          shadow_valid [DEPTH];
  logic [spq_pkg::PRIO_BITS-1:0] shadow_prio [DEPTH];
  logic [TAG_BITS-1:0]           shadow_tag [DEPTH];

  spq_pkg::out_item_t pending_results[$];
  dir_row_t           dir_rows[$];
  int                 mismatches = 0;
  int                 stall_pct = 0;
  bit                 quiet = 1'b0;
  bit                 hold_req = 1'b0;

  sorted_priority_queue #(
    .DEPTH    (DEPTH),
    .TAG_BITS (TAG_BITS)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  initial clk = 1'b0;
  always #(CLK_PERIOD / 2) clk = ~clk;

  // applies one item to the shadow queue and returns the result it causes
  function automatic spq_pkg::out_item_t queue_apply(spq_pkg::in_item_t it);
    spq_pkg::out_item_t                     res;
    logic [spq_pkg::PRIO_BITS+TAG_BITS-1:0] key;
    int                                     pos;
    int                                     count;
    res = '0;
    if (it.kind == spq_pkg::KIND_INSERT) begin
      if (it.has_priority) begin
        key = {it.priority_req, it.tag[TAG_BITS-1:0]};
        res.accepted = 1'b1;
        res.dropped = shadow_valid[DEPTH-1];
        pos = DEPTH;
        for (int i = DEPTH - 1; i >= 0; i--) begin
          if (!shadow_valid[i] || key > {shadow_prio[i], shadow_tag[i]}) pos = i;
        end
        // pos is the first slot holding a smaller entry, or an empty one
        if (pos < DEPTH) begin
          for (int i = DEPTH - 1; i > pos; i--) begin
            shadow_valid[i] = shadow_valid[i-1];
            shadow_prio[i] = shadow_prio[i-1];
            shadow_tag[i] = shadow_tag[i-1];
          end
          shadow_valid[pos] = 1'b1;
          shadow_prio[pos] = it.priority_req;
          shadow_tag[pos] = it.tag[TAG_BITS-1:0];
        end
      end
    end else if (shadow_valid[0]) begin
      res.accepted = 1'b1;
      res.removed_priority = shadow_prio[0];
      res.removed_tag = shadow_tag[0];
      for (int i = 0; i < DEPTH - 1; i++) begin
        shadow_valid[i] = shadow_valid[i+1];
        shadow_prio[i] = shadow_prio[i+1];
        shadow_tag[i] = shadow_tag[i+1];
      end
      shadow_valid[DEPTH-1] = 1'b0;
      shadow_prio[DEPTH-1] = '0;
      shadow_tag[DEPTH-1] = '0;
    end
    count = 0;
    for (int i = 0; i < DEPTH; i++) count += shadow_valid[i];
    res.top_valid = shadow_valid[0];
    res.top_priority = shadow_valid[0] ? shadow_prio[0] : '0;
    res.top_tag = shadow_valid[0] ? shadow_tag[0] : '0;
    res.occupancy = count[spq_pkg::OCC_BITS-1:0];
    return res;
  endfunction

  function automatic spq_pkg::in_item_t rand_item(int remove_pct);
    spq_pkg::in_item_t it;
    it.kind = ($urandom_range(0, 99) < remove_pct) ? spq_pkg::KIND_REMOVE :
                                                     spq_pkg::KIND_INSERT;
    it.has_priority = ($urandom_range(0, 99) < 92);
    it.priority_req = spq_pkg::PRIO_BITS'(($urandom_range(0, 99) < 88) ?
                                          $urandom_range(0, 9) :
                                          $urandom_range(10, 15));
    // a narrow tag pool makes equal keys common
    it.tag = spq_pkg::IO_TAG_BITS'(($urandom_range(0, 3) == 0) ?
                                   $urandom_range(0, 3) : $urandom);
    return it;
  endfunction

  task automatic add_row(logic kind, logic has_p, logic [3:0] prio, logic [15:0] tag,
                         bit typed, spq_pkg::out_item_t result);
    dir_row_t row;
    row.item = '{kind, has_p, prio, tag};
    row.typed = typed;
    row.result = result;
    dir_rows.push_back(row);
  endtask

  task automatic idle_input(int cycles);
    @(negedge clk);
    in_valid <= 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  task automatic send_item(spq_pkg::in_item_t it, bit typed,
                           spq_pkg::out_item_t typed_result);
    spq_pkg::out_item_t predicted;
    @(negedge clk);
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (in_stall);
    predicted = queue_apply(it);
    pending_results.push_back(typed ? typed_result : predicted);
  endtask

  task automatic report_field(string name, logic [15:0] want, logic [15:0] got);
    $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
    mismatches++;
  endtask

  always @(posedge clk) begin : result_check
    spq_pkg::out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, got %h", $time, out_item);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (out_item.accepted !== want.accepted)
          report_field("accepted", 16'(want.accepted), 16'(out_item.accepted));
        if (out_item.dropped !== want.dropped)
          report_field("dropped", 16'(want.dropped), 16'(out_item.dropped));
        if (out_item.removed_priority !== want.removed_priority)
          report_field("removed_priority", 16'(want.removed_priority),
                       16'(out_item.removed_priority));
        if (out_item.removed_tag !== want.removed_tag)
          report_field("removed_tag", want.removed_tag, out_item.removed_tag);
        if (out_item.top_valid !== want.top_valid)
          report_field("top_valid", 16'(want.top_valid), 16'(out_item.top_valid));
        if (out_item.top_priority !== want.top_priority)
          report_field("top_priority", 16'(want.top_priority),
                       16'(out_item.top_priority));
        if (out_item.top_tag !== want.top_tag)
          report_field("top_tag", want.top_tag, out_item.top_tag);
        if (out_item.occupancy !== want.occupancy)
          report_field("occupancy", 16'(want.occupancy), 16'(out_item.occupancy));
      end
    end
  end

  // result side: random stall bursts, one long hold on request
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !quiet) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 99) < stall_pct) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(0, 4)) @(negedge clk);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    #(CLK_PERIOD * 300000);
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    int remove_pct;
    int gap_pct;
    int picks [6];
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_item = '0;
    for (int i = 0; i < DEPTH; i++) begin
      shadow_valid[i] = 1'b0;
      shadow_prio[i] = '0;
      shadow_tag[i] = '0;
    end
    picks = '{10, 30, 45, 55, 70, 90};
    remove_pct = 40;
    gap_pct = 0;

    // fill to full, overflow both ways, then drain past empty
    add_row(spq_pkg::KIND_REMOVE, 1'b0, 4'd0, 16'h0000, 1'b1, '0);
    add_row(spq_pkg::KIND_INSERT, 1'b0, 4'd9, 16'hffff, 1'b1, '0);
    add_row(spq_pkg::KIND_INSERT, 1'b1, 4'd9, 16'hffff, 1'b1,
            '{1'b1, 1'b0, 4'd0, 16'h0, 1'b1, 4'd9, 16'hffff, 4'd1});
    add_row(spq_pkg::KIND_INSERT, 1'b1, 4'd0, 16'h0000, 1'b1,
            '{1'b1, 1'b0, 4'd0, 16'h0, 1'b1, 4'd9, 16'hffff, 4'd2});
    add_row(spq_pkg::KIND_INSERT, 1'b1, 4'd15, 16'h0000, 1'b1,
            '{1'b1, 1'b0, 4'd0, 16'h0, 1'b1, 4'd15, 16'h0000, 4'd3});
    add_row(spq_pkg::KIND_INSERT, 1'b1, 4'd9, 16'hffff, 1'b0, '0);
    add_row(spq_pkg::KIND_INSERT, 1'b1, 4'd5, 16'h1234, 1'b0, '0);
    add_row(spq_pkg::KIND_INSERT, 1'b1, 4'd5, 16'h1234, 1'b0, '0);
    add_row(spq_pkg::KIND_INSERT, 1'b1, 4'd3, 16'haaaa, 1'b0, '0);
    add_row(spq_pkg::KIND_INSERT, 1'b1, 4'd7, 16'h5555, 1'b0, '0);
    add_row(spq_pkg::KIND_INSERT, 1'b1, 4'd0, 16'h0000, 1'b0, '0);
    add_row(spq_pkg::KIND_INSERT, 1'b1, 4'd12, 16'h8000, 1'b0, '0);
    add_row(spq_pkg::KIND_INSERT, 1'b0, 4'd15, 16'hffff, 1'b0, '0);
    for (int i = 0; i < DEPTH; i++)
      add_row(spq_pkg::KIND_REMOVE, 1'b1, 4'd15, 16'hffff, 1'b0, '0);
    add_row(spq_pkg::KIND_REMOVE, 1'b1, 4'd0, 16'h0000, 1'b1, '0);
    add_row(spq_pkg::KIND_INSERT, 1'b1, 4'd1, 16'h0001, 1'b0, '0);
    add_row(spq_pkg::KIND_REMOVE, 1'b0, 4'd0, 16'h0000, 1'b0, '0);

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    stall_pct = 20;
    foreach (dir_rows[i]) begin
      if ($urandom_range(0, 99) < 25) idle_input($urandom_range(1, 5));
      send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].result);
    end

    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n % 75 == 0) begin
        remove_pct = picks[$urandom_range(0, 5)];
        gap_pct = ($urandom_range(0, 2) == 0) ? 0 : 20;
        stall_pct = ($urandom_range(0, 2) == 0) ? 0 : 20;
      end
      if (n == RAND_ITEMS - QUIET_ITEMS) begin
        quiet = 1'b1;
        gap_pct = 0;
      end
      if (n == 300) begin
        // back-to-back items while the result side holds off
        hold_req = 1'b1;
        gap_pct = 0;
      end
      if (n == 600) begin
        idle_input(1);
        while (pending_results.size() != 0) @(posedge clk);
      end
      if (!quiet && $urandom_range(0, 99) < gap_pct) idle_input($urandom_range(1, 5));
      send_item(rand_item(remove_pct), 1'b0, '0);
    end

    idle_input(1);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
